// File: rtl/hkx_pkg.sv
// Shared types and constants for the hash keystream XOR cipher.
`default_nettype none
package hkx_pkg;

  // Multiplier constant selects
  localparam logic [1:0] KSEL_MIX1  = 2'd0;
  localparam logic [1:0] KSEL_MIX2  = 2'd1;
  localparam logic [1:0] KSEL_HASH1 = 2'd2;
  localparam logic [1:0] KSEL_HASH2 = 2'd3;

  localparam logic [31:0] K_MIX1      = 32'h7FEB352D;
  localparam logic [31:0] K_MIX2      = 32'h846CA68B;
  localparam logic [31:0] K_HASH1     = 32'h2C1B3C6D;
  localparam logic [31:0] K_HASH2     = 32'h297A2D39;
  localparam logic [31:0] K_GOLDEN    = 32'h9E3779B9;
  localparam logic [31:0] K_SEED_TAG  = 32'h4C504B43;
  localparam logic [31:0] K_ARCH_WIDE = 32'hC0DEC064;
  localparam logic [31:0] K_ARCH_NARR = 32'hC0DEC032;
  localparam int          SEED_ROT    = 7;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RANGE_OFFSET = 2'd0;
  localparam logic [1:0] REG_RANGE_LENGTH = 2'd1;
  localparam logic [1:0] REG_ARCH_WIDE    = 2'd2;

  typedef struct packed {
    logic [31:0] range_offset;
    logic [30:0] range_length;
    logic        arch_wide;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [1:0]  ksel;
  } mul_req_t;

endpackage
`default_nettype wire

// File: rtl/hash_keystream_xor_cipher_unit.sv
// Top level of the hash keystream XOR cipher.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, data_byte, start_req  | in
//  output   | out_valid, out_stall, out_byte, last      | out
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB
//           | prdata, pready                            |
//
// A new byte is accepted only when idle or in the last byte's writeback; one with
// start_req first passes the seed steps. One shared 32-bit multiplier sets the
// pace: four (six with reseed) multiplies, a pre-add and a writeback, a step each.
// Reset (rst, synchronous) clears chain and byte index and sets register defaults.
// The result sits in an output register; a stalled output holds the next byte
// in its first mix step until the register frees.
`default_nettype none
module hash_keystream_xor_cipher_unit
  import hkx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_byte,
  output logic             last
);

  cfg_t        cfg;
  mul_req_t    mreq;
  logic [31:0] prod;

  hkx_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hkx_mult u_mult (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  hkx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .mreq      (mreq),
    .prod      (prod)
  );

endmodule
`default_nettype wire

// File: rtl/hkx_apb_regs.sv
// APB configuration registers of the cipher.
`default_nettype none
module hkx_apb_regs
  import hkx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Write registers; unmapped addresses drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_offset <= 32'd0;
      cfg.range_length <= 31'd1;
      cfg.arch_wide    <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RANGE_OFFSET: cfg.range_offset <= pwdata;
        REG_RANGE_LENGTH: cfg.range_length <= pwdata[30:0];
        REG_ARCH_WIDE:    cfg.arch_wide    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_RANGE_OFFSET: prdata = cfg.range_offset;
      REG_RANGE_LENGTH: prdata = {1'b0, cfg.range_length};
      REG_ARCH_WIDE:    prdata = {31'd0, cfg.arch_wide};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/hkx_mult.sv
// Shared 32-bit constant multiplier with registered low product.
`default_nettype none
module hkx_mult
  import hkx_pkg::*;
(
  input  wire logic        clk,
  input  wire mul_req_t    req,
  output logic      [31:0] prod
);

  logic [31:0] kval;

  // Decode constant select
  always_comb begin
    unique case (req.ksel)
      KSEL_MIX1:  kval = K_MIX1;
      KSEL_MIX2:  kval = K_MIX2;
      KSEL_HASH1: kval = K_HASH1;
      KSEL_HASH2: kval = K_HASH2;
      default:    kval = K_MIX1;
    endcase
  end

  // Multiply modulo 2^32 and hold until the next request
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * kval;
    end
  end

endmodule
`default_nettype wire

// File: rtl/hkx_core.sv
// Sequencer and datapath: seed, per-byte hash, chain update, output register.
`default_nettype none
module hkx_core
  import hkx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_byte,
  output logic             last,
  output mul_req_t         mreq,
  input  wire logic [31:0] prod
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEED_A = 4'd1;
  localparam logic [3:0] ST_SEED_B = 4'd2;
  localparam logic [3:0] ST_PRE    = 4'd3;
  localparam logic [3:0] ST_HASH_A = 4'd4;
  localparam logic [3:0] ST_HASH_B = 4'd5;
  localparam logic [3:0] ST_MIX_A  = 4'd6;
  localparam logic [3:0] ST_MIX_B  = 4'd7;
  localparam logic [3:0] ST_WB     = 4'd8;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [7:0]  data;
  logic        start;
  logic [31:0] chain;
  logic [30:0] idx;
  logic [31:0] hsum;

  logic        accept;
  logic        out_free;
  logic [31:0] len_rot;
  logic [31:0] seed_pre;
  logic [31:0] seed_val;
  logic [31:0] chain_use;
  logic [30:0] idx_use;
  logic [31:0] hash_x;
  logic [31:0] mix_in;
  logic [7:0]  ks;
  logic [31:0] chain_upd;

  assign in_stall = !((state == ST_IDLE) || (state == ST_WB));
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Seed input before the mixer
  assign len_rot  = {1'b0, cfg.range_length} << SEED_ROT
                  | {1'b0, cfg.range_length} >> (32 - SEED_ROT);
  assign seed_pre = K_SEED_TAG ^ cfg.range_offset ^ len_rot
                  ^ (cfg.arch_wide ? K_ARCH_WIDE : K_ARCH_NARR);

  // Finished mixer outputs from the shared product
  assign seed_val  = prod ^ (prod >> 16);
  assign chain_upd = prod ^ (prod >> 16);
  assign chain_use = start ? seed_val : chain;
  assign idx_use   = start ? 31'd0 : idx;

  // Hash output and keystream byte, valid in the first mix step
  assign hash_x = prod ^ (prod >> 15);
  assign mix_in = chain ^ hash_x ^ {1'b0, idx};
  always_comb begin
    case (idx[1:0])
      2'd0:    ks = hash_x[7:0];
      2'd1:    ks = hash_x[15:8];
      2'd2:    ks = hash_x[23:16];
      default: ks = hash_x[31:24];
    endcase
  end

  // Drive the shared multiplier
  always_comb begin
    mreq.en   = 1'b0;
    mreq.a    = 32'd0;
    mreq.ksel = KSEL_MIX1;
    unique case (state)
      ST_SEED_A: begin
        mreq.en   = 1'b1;
        mreq.a    = seed_pre ^ (seed_pre >> 16);
        mreq.ksel = KSEL_MIX1;
      end
      ST_SEED_B: begin
        mreq.en   = 1'b1;
        mreq.a    = prod ^ (prod >> 15);
        mreq.ksel = KSEL_MIX2;
      end
      ST_HASH_A: begin
        mreq.en   = 1'b1;
        mreq.a    = hsum ^ (hsum >> 15);
        mreq.ksel = KSEL_HASH1;
      end
      ST_HASH_B: begin
        mreq.en   = 1'b1;
        mreq.a    = prod ^ (prod >> 12);
        mreq.ksel = KSEL_HASH2;
      end
      ST_MIX_A: begin
        mreq.en   = out_free;
        mreq.a    = mix_in ^ (mix_in >> 16);
        mreq.ksel = KSEL_MIX1;
      end
      ST_MIX_B: begin
        mreq.en   = 1'b1;
        mreq.a    = prod ^ (prod >> 15);
        mreq.ksel = KSEL_MIX2;
      end
      default: ;
    endcase
  end

  // Next step of the sequencer
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE, ST_WB: begin
        if (accept) begin
          state_next = start_req ? ST_SEED_A : ST_PRE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEED_A: state_next = ST_SEED_B;
      ST_SEED_B: state_next = ST_PRE;
      ST_PRE:    state_next = ST_HASH_A;
      ST_HASH_A: state_next = ST_HASH_B;
      ST_HASH_B: state_next = ST_MIX_A;
      ST_MIX_A:  state_next = out_free ? ST_MIX_B : ST_MIX_A;
      ST_MIX_B:  state_next = ST_WB;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control state, chain and index
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      chain     <= 32'd0;
      idx       <= 31'd0;
    end else begin
      state <= state_next;
      if ((state == ST_MIX_A) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_PRE) begin
        chain <= chain_use;
        idx   <= idx_use;
      end
      if (state == ST_WB) begin
        chain <= chain_upd;
        idx   <= idx + 31'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      data  <= data_byte;
      start <= start_req;
    end
    if (state == ST_PRE) begin
      hsum <= chain_use + K_GOLDEN + {1'b0, idx_use};
    end
    if ((state == ST_MIX_A) && out_free) begin
      out_byte <= data ^ ks;
      last     <= (idx == (cfg.range_length - 31'd1));
    end
  end

endmodule
`default_nettype wire
